>>> rtl/core/kmsd_pkg.sv
// Package for the key matrix scanner with debounce.
// Holds the matrix size, the row entry layout of the state memory and the FSM states.
// No dependencies.
package kmsd_pkg;

	localparam int ROWS = 8;
	localparam int COLS = 8;
	localparam int ROW_W = 3;
	localparam int COL_W = 3;
	localparam int KEY_W = 6;
	localparam int CNT_W = 8;
	localparam logic [CNT_W-1:0] LOCKOUT_RESET = 8'd10;

	// One memory entry holds everything the block keeps for one matrix row.
	typedef struct packed {
		logic [COLS-1:0][CNT_W-1:0] lockout;
		logic [COLS-1:0]            smp_even;
		logic [COLS-1:0]            smp_odd;
		logic [COLS-1:0]            stable;
	} row_ent_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_UPD,
		ST_FE_RD,
		ST_FE_CHK,
		ST_FE_EMIT,
		ST_FE_FLUSH
	} state_t;

endpackage

>>> rtl/core/key_matrix_scan_debounce.sv
// Top level of the key matrix scanner with double-sample debounce and per-key lockout.
// Depends on kmsd_pkg for sizes, the row entry type and the state type.
// Contains the row state memory and the scan/frame-end sequencer.
//
// Usage:
//   The slave channel carries one scanned row per transaction: s_tdata[2:0] is the row
//   number, s_tdata[10:3] the active-low column levels. Each row is read from the row
//   memory and then written back with its updated lockout counters and samples. The row
//   memory has a single port with a registered read.
//   The last row ends the frame. The block then sweeps all rows, reading each one, writing
//   back the changes it takes over, then emitting one event for each key whose debounced
//   state changed; a closing step releases the held final event.
//   Every change leaves on the master channel as one transaction: m_tdata[5:0] is the
//   key index, m_tdata[6] the new state (1 pressed), and m_tlast marks the final event
//   of the frame. One event is held back in a lookahead register so m_tlast is known
//   when it leaves.
//   The sequencer works on one row transaction at a time; s_tready is high only when
//   it is idle. When the receiver stalls, the sweep waits until the output register
//   frees, so nothing is lost.
//   Reset clears the row valid flags, so every row reads as all zero until written;
//   the lockout register resets to 10 frames. cfg_we writes cfg_wdata into it.
module key_matrix_scan_debounce (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [15:0] s_tdata,    // [2:0] row_index, [10:3] column_levels, rest zero
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [7:0]  m_tdata,    // [5:0] key_index, [6] pressed, [7] zero
	output logic        m_tlast     // last_event
);
	import kmsd_pkg::*;

	localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(ROWS - 1);

	state_t state_q, state_d;

	// Row memory and its valid flags.
	row_ent_t           mem [ROWS];
	row_ent_t           rd_q;
	logic               rd_vld_q;
	logic [ROWS-1:0]    row_vld_q;
	logic               mem_we, mem_re;
	logic [ROW_W-1:0]   mem_wa, mem_ra;
	row_ent_t           mem_wd;
	row_ent_t           ent;

	// Item and sweep registers.
	logic [CNT_W-1:0]   lockout_q;
	logic               bsel_q;
	logic [ROW_W-1:0]   row_q;
	logic [COLS-1:0]    lv_q;
	logic [ROW_W-1:0]   fe_row_q;
	logic [COLS-1:0]    mask_q;
	logic [COLS-1:0]    stab_q;

	// Lookahead event and output register.
	logic               pend_vld_q;
	logic [KEY_W-1:0]   pend_key_q;
	logic               pend_prs_q;
	logic               out_vld_q;
	logic [KEY_W-1:0]   out_key_q;
	logic               out_prs_q;
	logic               out_last_q;

	logic               s_acc;
	logic               out_free;
	logic [ROW_W-1:0]   in_row;
	logic [COL_W-1:0]   lo_col;
	logic [KEY_W-1:0]   new_key;
	logic [COLS-1:0]    chg;
	logic               take_evt;
	logic               flush_evt;

	assign in_row   = s_tdata[ROW_W-1:0];
	assign s_tready = (state_q == ST_IDLE);
	assign s_acc    = s_tvalid && s_tready;
	assign out_free = !out_vld_q || m_tready;

	assign m_tvalid = out_vld_q;
	assign m_tdata  = {1'b0, out_prs_q, out_key_q};
	assign m_tlast  = out_last_q;

	// A row that has never been written reads as all zero.
	assign ent = rd_vld_q ? rd_q : '0;

	// Lowest pending change of the current row.
	always_comb begin
		lo_col = '0;
		for (int c = COLS - 1; c >= 0; c--) begin
			if (mask_q[c]) begin
				lo_col = COL_W'(c);
			end
		end
	end

	assign new_key = KEY_W'(fe_row_q) * KEY_W'(COLS) + KEY_W'(lo_col);

	always_comb begin
		for (int c = 0; c < COLS; c++) begin
			chg[c] = (ent.smp_even[c] == ent.smp_odd[c]) && (ent.smp_even[c] != ent.stable[c]);
		end
	end

	// Sequencer: next state, memory control and write data.
	always_comb begin
		state_d   = state_q;
		mem_we    = 1'b0;
		mem_wa    = row_q;
		mem_wd    = ent;
		mem_re    = 1'b0;
		mem_ra    = in_row;
		take_evt  = 1'b0;
		flush_evt = 1'b0;
		case (state_q)
			ST_IDLE: begin
				if (s_acc && ({1'b0, in_row} < (ROW_W + 1)'(ROWS))) begin
					mem_re  = 1'b1;
					state_d = ST_UPD;
				end
			end
			ST_UPD: begin
				// Locked keys count down; free keys take the new sample.
				mem_we = 1'b1;
				mem_wa = row_q;
				for (int c = 0; c < COLS; c++) begin
					if (ent.lockout[c] != '0) begin
						mem_wd.lockout[c] = ent.lockout[c] - CNT_W'(1);
					end else if (bsel_q) begin
						mem_wd.smp_odd[c] = ~lv_q[c];
					end else begin
						mem_wd.smp_even[c] = ~lv_q[c];
					end
				end
				state_d = (row_q == LAST_ROW) ? ST_FE_RD : ST_IDLE;
			end
			ST_FE_RD: begin
				mem_re  = 1'b1;
				mem_ra  = fe_row_q;
				state_d = ST_FE_CHK;
			end
			ST_FE_CHK: begin
				// Agreeing samples that differ from the stable state are taken over.
				mem_we = 1'b1;
				mem_wa = fe_row_q;
				for (int c = 0; c < COLS; c++) begin
					if (chg[c]) begin
						mem_wd.stable[c]  = ent.smp_even[c];
						mem_wd.lockout[c] = lockout_q;
					end
				end
				state_d = ST_FE_EMIT;
			end
			ST_FE_EMIT: begin
				if (mask_q != '0) begin
					take_evt = !pend_vld_q || out_free;
				end else if (fe_row_q == LAST_ROW) begin
					state_d = ST_FE_FLUSH;
				end else begin
					state_d = ST_FE_RD;
				end
			end
			ST_FE_FLUSH: begin
				if (!pend_vld_q) begin
					state_d = ST_IDLE;
				end else if (out_free) begin
					flush_evt = 1'b1;
					state_d   = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Single-port row memory with registered read.
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_wa] <= mem_wd;
		end
		if (mem_re) begin
			rd_q     <= mem[mem_ra];
			rd_vld_q <= row_vld_q[mem_ra];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_vld_q  <= '0;
			lockout_q  <= LOCKOUT_RESET;
			bsel_q     <= 1'b0;
			fe_row_q   <= '0;
			mask_q     <= '0;
			pend_vld_q <= 1'b0;
			out_vld_q  <= 1'b0;
		end else begin
			if (mem_we) begin
				row_vld_q[mem_wa] <= 1'b1;
			end
			if (cfg_we) begin
				lockout_q <= cfg_wdata;
			end
			if (state_q == ST_UPD && row_q == LAST_ROW) begin
				bsel_q   <= ~bsel_q;
				fe_row_q <= '0;
			end
			if (state_q == ST_FE_CHK) begin
				mask_q <= chg;
			end
			if (state_q == ST_FE_EMIT && mask_q == '0 && fe_row_q != LAST_ROW) begin
				fe_row_q <= fe_row_q + ROW_W'(1);
			end
			if (take_evt) begin
				mask_q[lo_col] <= 1'b0;
				pend_vld_q     <= 1'b1;
			end else if (flush_evt) begin
				pend_vld_q <= 1'b0;
			end
			// The held event leaves when a newer one replaces it or the sweep ends.
			if ((take_evt && pend_vld_q) || flush_evt) begin
				out_vld_q <= 1'b1;
			end else if (m_tready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	// Payload registers.
	always_ff @(posedge clk) begin
		if (s_acc) begin
			row_q <= in_row;
			lv_q  <= s_tdata[ROW_W +: COLS];
		end
		if (state_q == ST_FE_CHK) begin
			stab_q <= mem_wd.stable;
		end
		if (take_evt) begin
			pend_key_q <= new_key;
			pend_prs_q <= stab_q[lo_col];
		end
		if ((take_evt && pend_vld_q) || flush_evt) begin
			out_key_q  <= pend_key_q;
			out_prs_q  <= pend_prs_q;
			out_last_q <= flush_evt;
		end
	end

endmodule

>>> tb/sv/key_matrix_scan_debounce_tb.sv
`timescale 1ns / 100ps
// Self-checking testbench for key_matrix_scan_debounce: a queue-fed row driver, an event
// monitor and a debounce predictor that keeps its own copy of the key state.
// Depends on kmsd_pkg for the matrix size and the counter width.
module key_matrix_scan_debounce_tb;
	import kmsd_pkg::*;

	localparam int KEY_TOTAL   = ROWS * COLS;
	// Settling time, comfortably more than a full frame-end sweep with every key changing.
	localparam int SETTLE      = 200;
	localparam int IDLE_LIMIT  = 4000;

	typedef struct packed {
		logic [ROW_W-1:0] row;
		logic [7:0]       levels;
	} scan_row_t;

	typedef struct packed {
		logic [KEY_W-1:0] key;
		logic             pressed;
		logic             last;
	} key_event_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [7:0]  cfg_wdata = 8'd0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = 16'd0;    // [2:0] row_index, [10:3] column_levels, rest zero
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [7:0]  m_tdata;            // [5:0] key_index, [6] pressed, [7] zero
	logic        m_tlast;            // last_event

	key_matrix_scan_debounce dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Predicted key state. It mirrors the block's registers and is advanced once for
	// every row transaction accepted at the slave port.
	logic [CNT_W-1:0] lockout_frames_cfg = LOCKOUT_RESET;
	logic [KEY_TOTAL-1:0] smp_even = '0;
	logic [KEY_TOTAL-1:0] smp_odd = '0;
	logic [KEY_TOTAL-1:0] stable_keys = '0;
	logic [CNT_W-1:0] lockout_cnt [KEY_TOTAL];
	logic buf_sel = 1'b0;

	scan_row_t  scan_queue [$];      // rows waiting to be driven
	key_event_t pending_events [$];  // events predicted but not yet seen
	int rows_queued = 0;
	int rows_taken = 0;
	int errors = 0;
	int idle_cycles = 0;

	// Handshake bookkeeping between the rising-edge sampler and the falling-edge driver.
	logic row_taken = 1'b0;
	int burst_left = 1;
	int gap_left = 0;
	int ready_mode = 0;
	int span_left = 0;
	logic [7:0] held_levels [ROWS];

	initial begin
		for (int k = 0; k < KEY_TOTAL; k++)
			lockout_cnt[k] = '0;
	end

	// Applies one scanned row to the predicted state. Rows other than the last one only
	// update samples and lockout counters; the last row ends the frame and appends one
	// event per key whose two samples agree and differ from its debounced state.
	task automatic debounce_row(input logic [ROW_W-1:0] row, input logic [7:0] levels);
		key_event_t ev;
		int key;
		int c;
		int k;
		int last_key;
		for (c = 0; c < COLS; c++) begin
			key = row * COLS + c;
			if (lockout_cnt[key] != '0)
				lockout_cnt[key] = lockout_cnt[key] - 1'b1;
			else if (buf_sel)
				smp_odd[key] = ~levels[c];
			else
				smp_even[key] = ~levels[c];
		end
		if (row == ROW_W'(ROWS - 1)) begin
			buf_sel = ~buf_sel;
			// First find the last key that changes, so its event can carry the last flag.
			last_key = -1;
			for (k = 0; k < KEY_TOTAL; k++)
				if (smp_even[k] == smp_odd[k] && smp_even[k] != stable_keys[k])
					last_key = k;
			for (k = 0; k < KEY_TOTAL; k++) begin
				if (smp_even[k] == smp_odd[k] && smp_even[k] != stable_keys[k]) begin
					stable_keys[k] = smp_even[k];
					lockout_cnt[k] = lockout_frames_cfg;
					ev.key = KEY_W'(k);
					ev.pressed = stable_keys[k];
					ev.last = (k == last_key);
					pending_events.push_back(ev);
				end
			end
		end
	endtask

	task automatic queue_row(input int row, input logic [7:0] levels);
		scan_row_t item;
		item.row = ROW_W'(row);
		item.levels = levels;
		scan_queue.push_back(item);
		rows_queued++;
	endtask

	// Blocks until every queued row has been taken and every predicted event has left,
	// then lets a full sweep's worth of cycles pass so the block is surely idle.
	task automatic drain_and_settle();
		while (rows_taken != rows_queued || pending_events.size() != 0)
			@(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic write_lockout(input logic [7:0] value);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// Random rows, mostly shaped as whole frames over a slowly changing key pattern so that
	// the two samples agree and keys actually settle. A few frames start part way through,
	// some carry a glitch on one row, now and then the whole matrix flips, and a small share
	// of rows are pure noise.
	task automatic queue_random(input int count);
		int n;
		int r;
		int first;
		logic [7:0] lv;
		n = 0;
		while (n < count) begin
			case ($urandom_range(0, 9))
				0: begin
					queue_row($urandom_range(0, ROWS - 1), 8'($urandom));
					n++;
				end
				1: begin
					first = $urandom_range(1, ROWS - 2);
					for (r = first; r < ROWS; r++)
						queue_row(r, held_levels[r]);
					n += ROWS - first;
				end
				default: begin
					if ($urandom_range(0, 11) == 0) begin
						for (r = 0; r < ROWS; r++)
							held_levels[r] = ~held_levels[r];
					end else if ($urandom_range(0, 2) == 0) begin
						r = $urandom_range(0, ROWS - 1);
						if ($urandom_range(0, 3) == 0)
							held_levels[r] = 8'($urandom);
						else
							held_levels[r] ^= 8'(1 << $urandom_range(0, 7));
					end
					for (r = 0; r < ROWS; r++) begin
						lv = held_levels[r];
						if ($urandom_range(0, 15) == 0)
							lv = 8'($urandom);
						queue_row(r, lv);
					end
					n += ROWS;
				end
			endcase
		end
	endtask

	// Row driver: presents the next queued row at the falling edge once the current one
	// has been taken, in bursts of random length separated by random gaps.
	always @(negedge clk) begin
		scan_row_t item;
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (!s_tvalid || row_taken) begin
			row_taken = 1'b0;
			if (gap_left > 0) begin
				gap_left--;
				s_tvalid <= 1'b0;
			end else if (scan_queue.size() == 0) begin
				s_tvalid <= 1'b0;
			end else begin
				item = scan_queue.pop_front();
				s_tdata <= {5'b0, item.levels, item.row};
				s_tvalid <= 1'b1;
				if (burst_left > 1) begin
					burst_left--;
				end else begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end
		end
	end

	// Event receiver back-pressure. The mode changes after a random span, switching between
	// always ready, a coin toss per cycle, and mostly stalled.
	always @(negedge clk) begin
		if (span_left == 0) begin
			ready_mode = $urandom_range(0, 2);
			span_left = $urandom_range(20, 120);
		end else begin
			span_left--;
		end
		case (ready_mode)
			0:       m_tready <= 1'b1;
			1:       m_tready <= 1'($urandom_range(0, 1));
			default: m_tready <= ($urandom_range(0, 7) == 0);
		endcase
	end

	// Rising-edge sampler: mirrors register writes, feeds accepted rows to the predictor
	// and checks every event transaction against the oldest prediction.
	always @(posedge clk) begin
		key_event_t ev;
		if (cfg_we)
			lockout_frames_cfg = cfg_wdata;
		if (s_tvalid && s_tready) begin
			debounce_row(s_tdata[2:0], s_tdata[10:3]);
			rows_taken++;
			row_taken = 1'b1;
		end
		if (m_tvalid && m_tready) begin
			if (pending_events.size() == 0) begin
				errors++;
				$display("%0t: unexpected event: expected none, got key %0d pressed %0b last %0b",
					$time, m_tdata[5:0], m_tdata[6], m_tlast);
			end else begin
				ev = pending_events.pop_front();
				if (m_tdata[5:0] !== ev.key || m_tdata[6] !== ev.pressed || m_tlast !== ev.last) begin
					errors++;
					$display("%0t: event mismatch: expected key %0d pressed %0b last %0b, got key %0d pressed %0b last %0b",
						$time, ev.key, ev.pressed, ev.last, m_tdata[5:0], m_tdata[6], m_tlast);
				end
			end
		end
	end

	// Watchdog: ends the run when nothing at all is accepted for too long.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			idle_cycles = 0;
		else
			idle_cycles++;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("%0t: no transaction for %0d cycles", $time, IDLE_LIMIT);
			$display("*** FAILED ***");
			$finish;
		end
	end

	initial begin
		for (int r = 0; r < ROWS; r++)
			held_levels[r] = 8'($urandom);
		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		repeat (5) @(posedge clk);

		// Directed part, with lockout disabled so every settled change shows up.
		write_lockout(8'd0);
		queue_row(7, 8'hFF);    // frame end with nothing changing
		queue_row(7, 8'h00);
		queue_row(7, 8'h00);    // last row pressed on both samples: eight presses
		queue_row(0, 8'h00);
		queue_row(7, 8'h00);
		queue_row(0, 8'h00);
		queue_row(7, 8'h00);    // first row joins
		queue_row(0, 8'hFF);
		queue_row(7, 8'hFF);
		queue_row(0, 8'hFF);
		queue_row(7, 8'hFF);    // sixteen releases in one frame end
		queue_row(3, 8'h5A);
		queue_row(7, 8'hA5);
		queue_row(3, 8'h5A);
		queue_row(7, 8'hA5);    // mixed patterns on two rows
		queue_row(6, 8'h00);    // rows that do not end the frame
		queue_row(6, 8'hFF);
		queue_row(5, 8'h0F);
		queue_row(7, 8'hFF);
		queue_row(5, 8'h0F);
		queue_row(7, 8'hFF);
		queue_random(70);
		drain_and_settle();

		// Each phase below starts from an idle block, so the sender is held until all
		// events of the previous phase have arrived.
		write_lockout(LOCKOUT_RESET);
		queue_random(50);
		drain_and_settle();

		write_lockout(8'd1);
		queue_random(60);
		drain_and_settle();

		write_lockout(8'd3);
		queue_random(50);
		drain_and_settle();

		write_lockout(8'($urandom_range(2, 20)));
		queue_random(40);
		drain_and_settle();

		// Longest lockout last: keys that change here stay frozen for the rest of the run.
		write_lockout(8'd255);
		queue_random(50);
		drain_and_settle();

		if (errors == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule

>>> filelist.f
rtl/core/kmsd_pkg.sv
rtl/core/key_matrix_scan_debounce.sv
tb/sv/key_matrix_scan_debounce_tb.sv
